### rtl/row_norm_condition_estimate_defines.svh
// Assertion macros shared by the files that check this block.
// All of them sample on the rising edge of clock and are quiet while reset is high.
`ifndef ROW_NORM_CONDITION_ESTIMATE_DEFINES_SVH
`define ROW_NORM_CONDITION_ESTIMATE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RNCE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RNCE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/rnce_pkg.sv
package rnce_pkg;

   // Row geometry. The request item always carries nine columns; only the
   // first NUM_AXES of them enter the norm.
   localparam int NUM_COLS  = 9;
   localparam int NUM_AXES  = 9;
   localparam int MAX_ROWS  = 9;
   localparam int COL_W     = 28;
   localparam int MAG_W     = COL_W;
   localparam int SQR_W     = 2 * MAG_W;
   localparam int NORM_W    = 58;

   // Squaring runs SQ_LANES multipliers over SQ_STEPS steps.
   localparam int SQ_LANES  = 3;
   localparam int SQ_STEPS  = (NUM_AXES + SQ_LANES - 1) / SQ_LANES;
   localparam int MAG_SLOTS = SQ_STEPS * SQ_LANES;

   // Ratio and root. The dividend is largest * 2^32, so the quotient is
   // DVD_W bits and its integer square root is half as wide.
   localparam int FRAC_SHIFT = 32;
   localparam int DVD_W      = NORM_W + FRAC_SHIFT;
   localparam int ROOT_W     = DVD_W / 2;
   localparam int RREM_W     = ROOT_W + 1;
   localparam int OUT_W      = 48;
   localparam int DIV_STEPS  = DVD_W;
   localparam int ROOT_STEPS = ROOT_W;
   localparam int CNT_W      = $clog2(DIV_STEPS);

   // Row counting.
   localparam int JC_W     = 4;
   localparam int ROWS_W   = 4;
   localparam int LIMIT_W  = $clog2(MAX_ROWS + 1);
   localparam int CMP_W    = (LIMIT_W > JC_W) ? LIMIT_W : JC_W;
   localparam int JC_RESET = 9;

   localparam logic [OUT_W-1:0] ONE_Q16 = OUT_W'(1) << 16;

   // Register file.
   localparam int DATA_W    = 32;
   localparam int PADDR_W   = 3;
   localparam int REG_IDX_W = 1;
   localparam logic [REG_IDX_W-1:0] REG_JOINT_COUNT   = 1'b0;
   localparam logic [REG_IDX_W-1:0] REG_IDENTITY_MODE = 1'b1;

   typedef struct packed {
      logic signed [COL_W-1:0] col_0;
      logic signed [COL_W-1:0] col_1;
      logic signed [COL_W-1:0] col_2;
      logic signed [COL_W-1:0] col_3;
      logic signed [COL_W-1:0] col_4;
      logic signed [COL_W-1:0] col_5;
      logic signed [COL_W-1:0] col_6;
      logic signed [COL_W-1:0] col_7;
      logic signed [COL_W-1:0] col_8;
   } req_type;

   typedef struct packed {
      logic [OUT_W-1:0] cond_estimate;
      logic             saturated;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_UPDATE,
      ST_FINISH,
      ST_DIVIDE,
      ST_ROOT,
      ST_RESULT
   } state_type;

   typedef enum logic [1:0] {
      RES_ROOT,
      RES_ZERO,
      RES_ONE
   } res_sel_type;

   typedef struct packed {
      logic        capture;
      logic        sq_en;
      logic        acc_en;
      logic        update;
      logic        div_load;
      logic        div_step;
      logic        root_step;
      logic        emit;
      res_sel_type res_sel;
   } ctrl_cmd_type;

   typedef struct packed {
      logic largest_zero;
   } dp_status_type;

endpackage

### rtl/row_norm_condition_estimate.sv
// Channel   Ports                                   Dir     Transfer
// request   start, busy, req_data                   in      item taken when start && !busy
// result    rsp_valid, rsp_data                     out     one-cycle strobe, no back-pressure
// config    psel penable pwrite paddr pwdata        in      APB write, pready tied high
//           prdata pready                           out
//
// A row that does not close its matrix holds busy through three squaring steps of three lanes
// and then one compare; a new row is taken only once busy is low again.
// The closing row adds a finish state, 90 divide steps, 45 root steps and a result state;
// in identity mode or when every row was zero, finish goes straight to result.
// The result strobe is high in the first cycle with busy low again.
// Synchronous reset clears control, row count, extremes, identity mode; joint count to 9. Results never stall.
module row_norm_condition_estimate (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  rnce_pkg::req_type             req_data,
   output logic                          rsp_valid,
   output rnce_pkg::rsp_type             rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [rnce_pkg::PADDR_W-1:0]  paddr,
   input  logic [rnce_pkg::DATA_W-1:0]   pwdata,
   output logic [rnce_pkg::DATA_W-1:0]   prdata,
   output logic                          pready
);
   import rnce_pkg::*;

   `include "row_norm_condition_estimate_defines.svh"

   logic [JC_W-1:0]      joint_count_ff;
   logic                 identity_mode_ff;
   logic [REG_IDX_W-1:0] csr_idx;
   logic                 csr_write;
   ctrl_cmd_type         cmd;
   dp_status_type        status;

   // Registers sit on 32-bit words; the low two address bits are ignored.
   assign csr_idx   = paddr[PADDR_W-1:2];
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      unique case (csr_idx)
         REG_JOINT_COUNT:   prdata = DATA_W'(joint_count_ff);
         REG_IDENTITY_MODE: prdata = DATA_W'(identity_mode_ff);
         default:           prdata = '0;
      endcase
   end

   // Only the register's own bits are kept; the rest of the write data is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         joint_count_ff   <= JC_W'(JC_RESET);
         identity_mode_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_idx)
            REG_JOINT_COUNT:   joint_count_ff   <= pwdata[JC_W-1:0];
            REG_IDENTITY_MODE: identity_mode_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   // The controller sequences squaring, the compare against the running
   // extremes, and at the end of a matrix the divide and root passes.
   rnce_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .joint_count   (joint_count_ff),
      .identity_mode (identity_mode_ff),
      .status        (status),
      .busy          (busy),
      .cmd           (cmd)
   );

   // The datapath holds the row magnitudes, the squared norm, the largest and
   // smallest nonzero norms, and the shared shift register of the divider and
   // root unit.
   rnce_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // A result is only issued once the sequencer is back at rest.
   `RNCE_ASSERT_NOW(a_rsp_when_idle, rsp_valid, !busy, "result strobe while busy")

   // A matrix produces one strobe; the next can come at the earliest a row later.
   `RNCE_ASSERT_NEXT(a_rsp_single, rsp_valid, !rsp_valid, "result strobe held two cycles")

   // An accepted row always occupies the block in the following cycle.
   `RNCE_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted row did not raise busy")

endmodule

### rtl/rnce_ctrl.sv
module rnce_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [rnce_pkg::JC_W-1:0] joint_count,
   input  logic                     identity_mode,
   input  rnce_pkg::dp_status_type  status,
   output logic                     busy,
   output rnce_pkg::ctrl_cmd_type   cmd
);
   import rnce_pkg::*;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [ROWS_W-1:0] rows_seen_ff, rows_seen_in;
   logic [ROWS_W-1:0] rows_next;
   logic [CMP_W-1:0]  jc_ext, limit;
   logic              last_row;

   // A count of zero behaves as one, and a count above MAX_ROWS as MAX_ROWS.
   always_comb begin
      jc_ext = CMP_W'(joint_count);
      if (jc_ext == '0) begin
         limit = CMP_W'(1);
      end else if (jc_ext > CMP_W'(MAX_ROWS)) begin
         limit = CMP_W'(MAX_ROWS);
      end else begin
         limit = jc_ext;
      end
      rows_next = (rows_seen_ff != '1) ? rows_seen_ff + 1'b1 : rows_seen_ff;
      last_row  = CMP_W'(rows_next) >= limit;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            if (cnt_ff == CNT_W'(SQ_STEPS - 1)) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = last_row ? ST_FINISH : ST_IDLE;
         end
         ST_FINISH: begin
            if (identity_mode || status.largest_zero) begin
               state_in = ST_RESULT;
            end else begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (cnt_ff == CNT_W'(ROOT_STEPS - 1)) state_in = ST_RESULT;
         end
         ST_RESULT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The step counter restarts whenever the state changes.
   always_comb begin
      cnt_in = '0;
      if (state_in == state_ff &&
          (state_ff == ST_SQUARE || state_ff == ST_DIVIDE || state_ff == ST_ROOT)) begin
         cnt_in = cnt_ff + 1'b1;
      end
      rows_seen_in = rows_seen_ff;
      if (state_ff == ST_UPDATE) begin
         rows_seen_in = rows_next;
      end else if (state_ff == ST_RESULT) begin
         rows_seen_in = '0;
      end
   end

   always_comb begin
      busy = state_ff != ST_IDLE;
      cmd  = '0;
      if (identity_mode) begin
         cmd.res_sel = RES_ONE;
      end else if (status.largest_zero) begin
         cmd.res_sel = RES_ZERO;
      end else begin
         cmd.res_sel = RES_ROOT;
      end
      unique case (state_ff)
         ST_IDLE:   cmd.capture   = start;
         ST_SQUARE: begin
            cmd.sq_en  = 1'b1;
            cmd.acc_en = cnt_ff != '0;
         end
         ST_UPDATE: cmd.update    = 1'b1;
         ST_FINISH: cmd.div_load  = 1'b1;
         ST_DIVIDE: cmd.div_step  = 1'b1;
         ST_ROOT:   cmd.root_step = 1'b1;
         ST_RESULT: cmd.emit      = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rows_seen_ff <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rows_seen_ff <= rows_seen_in;
      end
   end

endmodule

### rtl/rnce_dp.sv
module rnce_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  rnce_pkg::req_type      req_data,
   input  rnce_pkg::ctrl_cmd_type cmd,
   output rnce_pkg::dp_status_type status,
   output logic                   rsp_valid,
   output rnce_pkg::rsp_type      rsp_data
);
   import rnce_pkg::*;

   function automatic logic [MAG_W-1:0] magnitude(input logic [COL_W-1:0] v);
      logic [MAG_W-1:0] u;
      u = MAG_W'(v);
      return u[MAG_W-1] ? (~u + 1'b1) : u;
   endfunction

   logic [COL_W-1:0]           col_arr [NUM_COLS];
   logic [MAG_SLOTS*MAG_W-1:0] mag_vec_ff, mag_vec_in;
   logic [SQR_W-1:0]           prod_ff [SQ_LANES];
   logic [NORM_W-1:0]          norm_ff, norm_sum, prod_sum;
   logic [NORM_W-1:0]          largest_ff, smallest_ff;

   logic [DVD_W-1:0]           dq_ff;
   logic [NORM_W-1:0]          drem_ff;
   logic [NORM_W:0]            drem_sh;
   logic                       div_ge;

   logic [ROOT_W-1:0]          root_ff;
   logic [RREM_W-1:0]          rrem_ff;
   logic [RREM_W+1:0]          rrem_sh, rtrial;
   logic                       root_ge;

   logic                       rsp_valid_ff;
   rsp_type                    rsp_data_ff, rsp_data_in;

   always_comb begin
      col_arr[0] = req_data.col_0;
      col_arr[1] = req_data.col_1;
      col_arr[2] = req_data.col_2;
      col_arr[3] = req_data.col_3;
      col_arr[4] = req_data.col_4;
      col_arr[5] = req_data.col_5;
      col_arr[6] = req_data.col_6;
      col_arr[7] = req_data.col_7;
      col_arr[8] = req_data.col_8;
      mag_vec_in = '0;
      for (int i = 0; i < NUM_AXES; i++) begin
         mag_vec_in[i*MAG_W +: MAG_W] = magnitude(col_arr[i]);
      end
   end

   always_comb begin
      prod_sum = '0;
      for (int l = 0; l < SQ_LANES; l++) begin
         prod_sum = prod_sum + NORM_W'(prod_ff[l]);
      end
      norm_sum = norm_ff + prod_sum;
   end

   // One quotient bit per step.
   always_comb begin
      drem_sh = {drem_ff, dq_ff[DVD_W-1]};
      div_ge  = drem_sh >= {1'b0, smallest_ff};
   end

   // One root bit per step, taking two radicand bits.
   always_comb begin
      rrem_sh = {rrem_ff, dq_ff[DVD_W-1 -: 2]};
      rtrial  = (RREM_W+2)'({root_ff, 2'b01});
      root_ge = rrem_sh >= rtrial;
   end

   // The quotient stays below 2^DVD_W, so its root fits the output without
   // clamping and saturated is never raised.
   always_comb begin
      rsp_data_in.saturated = 1'b0;
      case (cmd.res_sel)
         RES_ONE:  rsp_data_in.cond_estimate = ONE_Q16;
         RES_ZERO: rsp_data_in.cond_estimate = '0;
         default:  rsp_data_in.cond_estimate = OUT_W'(root_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mag_vec_ff <= mag_vec_in;
      end else if (cmd.sq_en) begin
         mag_vec_ff <= mag_vec_ff >> (SQ_LANES * MAG_W);
      end
      if (cmd.sq_en) begin
         for (int l = 0; l < SQ_LANES; l++) begin
            prod_ff[l] <= mag_vec_ff[l*MAG_W +: MAG_W] * mag_vec_ff[l*MAG_W +: MAG_W];
         end
      end
      if (cmd.capture) begin
         norm_ff <= '0;
      end else if (cmd.acc_en) begin
         norm_ff <= norm_sum;
      end
      if (cmd.div_load) begin
         dq_ff   <= {largest_ff, {FRAC_SHIFT{1'b0}}};
         drem_ff <= '0;
         root_ff <= '0;
         rrem_ff <= '0;
      end else if (cmd.div_step) begin
         dq_ff   <= {dq_ff[DVD_W-2:0], div_ge};
         drem_ff <= div_ge ? NORM_W'(drem_sh - {1'b0, smallest_ff}) : NORM_W'(drem_sh);
      end else if (cmd.root_step) begin
         dq_ff   <= dq_ff << 2;
         root_ff <= {root_ff[ROOT_W-2:0], root_ge};
         rrem_ff <= root_ge ? RREM_W'(rrem_sh - rtrial) : RREM_W'(rrem_sh);
      end
      if (cmd.emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         largest_ff   <= '0;
         smallest_ff  <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
         if (cmd.emit) begin
            largest_ff  <= '0;
            smallest_ff <= '1;
         end else if (cmd.update) begin
            if (norm_sum > largest_ff) largest_ff <= norm_sum;
            if (norm_sum != '0 && norm_sum < smallest_ff) smallest_ff <= norm_sum;
         end
      end
   end

   assign status.largest_zero = largest_ff == '0;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_data            = rsp_data_ff;

endmodule
